### design/ppct_pkg.sv
// shared constants, codes and types of the point-in-path crossing test
package ppct_pkg;

  localparam int MAX_ELEMENTS_DEF = 256;
  localparam int COORD_WIDTH_DEF  = 32;

  // evaluator stages between an edge entering and its crossing bit
  localparam int PIPE_DEPTH = 3;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] ELEM_MOVETO  = 2'd0;
  localparam logic [1:0] ELEM_LINETO  = 2'd1;
  localparam logic [1:0] ELEM_CLOSE   = 2'd2;
  localparam logic [1:0] ELEM_INVALID = 2'd3;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

endpackage

### design/ppct_cell.sv
// one cell of the element ring: holds one path element, loads or shifts
module ppct_cell #(
  parameter int COORD_WIDTH = ppct_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  ppct_pkg::cell_ctl_t           ctl,
  input  logic [1:0]                    load_type,
  input  logic signed [COORD_WIDTH-1:0] load_x,
  input  logic signed [COORD_WIDTH-1:0] load_y,
  input  logic [1:0]                    nb_type,
  input  logic signed [COORD_WIDTH-1:0] nb_x,
  input  logic signed [COORD_WIDTH-1:0] nb_y,
  output logic [1:0]                    elem_type,
  output logic signed [COORD_WIDTH-1:0] elem_x,
  output logic signed [COORD_WIDTH-1:0] elem_y
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      elem_type <= load_type;
      elem_x    <= load_x;
      elem_y    <= load_y;
    end else if (ctl.shift) begin
      elem_type <= nb_type;
      elem_x    <= nb_x;
      elem_y    <= nb_y;
    end
  end

endmodule

### design/ppct_edge.sv
// pipelined exact edge crossing test against a ray toward +x
module ppct_edge #(
  parameter int COORD_WIDTH = ppct_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          edge_valid,
  input  logic signed [COORD_WIDTH-1:0] x1,
  input  logic signed [COORD_WIDTH-1:0] y1,
  input  logic signed [COORD_WIDTH-1:0] x2,
  input  logic signed [COORD_WIDTH-1:0] y2,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  output logic                          toggle
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;

  logic                 s1_valid;
  logic signed [W-1:0]  s1_x1, s1_y1, s1_x2, s1_y2;

  logic                 swap, horiz, in_range, right_of, vert;
  logic signed [W-1:0]  xa, ya, xb, yb, xmax;
  logic signed [DW-1:0] dxp, dye, dyp, dxe;

  logic                 s2_valid, s2_vert;
  logic signed [DW-1:0] s2_dxp, s2_dye, s2_dyp, s2_dxe;

  logic                 s3_valid, s3_vert;
  logic signed [PW-1:0] s3_lhs, s3_rhs;

  // orient the edge upward, then range checks and differences
  always_comb begin
    swap     = s1_y1 > s1_y2;
    horiz    = s1_y1 == s1_y2;
    xa       = swap ? s1_x2 : s1_x1;
    ya       = swap ? s1_y2 : s1_y1;
    xb       = swap ? s1_x1 : s1_x2;
    yb       = swap ? s1_y1 : s1_y2;
    in_range = (py > ya) && (py <= yb);
    xmax     = (xa > xb) ? xa : xb;
    right_of = px > xmax;
    vert     = xa == xb;
    dxp      = $signed({px[W-1], px}) - $signed({xa[W-1], xa});
    dye      = $signed({yb[W-1], yb}) - $signed({ya[W-1], ya});
    dyp      = $signed({py[W-1], py}) - $signed({ya[W-1], ya});
    dxe      = $signed({xb[W-1], xb}) - $signed({xa[W-1], xa});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= edge_valid;
      s2_valid <= s1_valid && !horiz && in_range && !right_of;
      s3_valid <= s2_valid;
    end
    s1_x1  <= x1;
    s1_y1  <= y1;
    s1_x2  <= x2;
    s1_y2  <= y2;
    s2_vert <= vert;
    s2_dxp <= dxp;
    s2_dye <= dye;
    s2_dyp <= dyp;
    s2_dxe <= dxe;
    s3_vert <= s2_vert;
    // px is left of or on the intersection when (px-xa)*(yb-ya) <= (py-ya)*(xb-xa)
    s3_lhs <= s2_dxp * s2_dye;
    s3_rhs <= s2_dyp * s2_dxe;
  end

  assign toggle = s3_valid && (s3_vert || (s3_lhs <= s3_rhs));

endmodule

### design/point_in_path_crossing_test.sv
// top level: element ring of cells, bounding box, walk control and output skid
// clear, append, kind 3, boxed-out, empty queries: result registered, one per cycle if none pends
// a full query gives its result from ST_RESULT: the ring rotates once through all cells
// (one element a cycle), then the 3 evaluator stages drain
// next request taken in ST_IDLE once the result has left the pending slot: queries never overlap
// reset (rst, synchronous) empties the path, drops the box and the output; cells keep data
module point_in_path_crossing_test #(
  parameter  int MAX_ELEMENTS = ppct_pkg::MAX_ELEMENTS_DEF,
  parameter  int COORD_WIDTH  = ppct_pkg::COORD_WIDTH_DEF,
  localparam int COUNT_WIDTH  = $clog2(MAX_ELEMENTS + 1),
  localparam int IN_DATA_W    = ((2 + 2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W   = ((2 + COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [1:0]            s_tuser,   // kind
  input  logic [IN_DATA_W-1:0]  s_tdata,   // element_type, coord_x, coord_y
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // inside_res, status, element_count
);

  import ppct_pkg::*;

  localparam int W           = COORD_WIDTH;
  localparam int IDX_WIDTH   = $clog2(MAX_ELEMENTS);
  localparam int DRAIN_WIDTH = $clog2(PIPE_DEPTH);

  logic [1:0]          in_kind, in_type;
  logic signed [W-1:0] in_x, in_y;
  logic                accept;

  state_t                 state, state_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic                   box_valid;
  logic signed [W-1:0]    box_min_x, box_max_x, box_min_y, box_max_y;
  logic signed [W-1:0]    qx, qy, p1x, p1y, fx, fy;
  logic [IDX_WIDTH-1:0]   idx;
  logic [DRAIN_WIDTH-1:0] drain_cnt;
  logic                   odd;

  logic                   full, box_out, boxed, load_en, box_load, walk_start;
  logic                   res_valid, res_inside, res_status;
  logic [COUNT_WIDTH-1:0] res_count;
  logic [OUT_DATA_W-1:0]  res_word, pend_word;
  logic                   pend_valid;

  logic [1:0]          cell_type [MAX_ELEMENTS];
  logic signed [W-1:0] cell_x    [MAX_ELEMENTS];
  logic signed [W-1:0] cell_y    [MAX_ELEMENTS];
  cell_ctl_t           cell_ctl  [MAX_ELEMENTS];

  logic                live, first, edge_valid, toggle;
  logic [1:0]          head_type;
  logic signed [W-1:0] head_x, head_y, end_x, end_y;

  assign in_kind  = s_tuser;
  assign in_type  = s_tdata[1:0];
  assign in_x     = s_tdata[W+1:2];
  assign in_y     = s_tdata[2*W+1:W+2];
  assign s_tready = (state == ST_IDLE) && !pend_valid;
  assign accept   = s_tvalid && s_tready;

  assign full    = count >= COUNT_WIDTH'(MAX_ELEMENTS);
  assign box_out = box_valid && ((in_x < box_min_x) || (in_x > box_max_x) ||
                                 (in_y < box_min_y) || (in_y > box_max_y));
  assign boxed   = (in_type == ELEM_MOVETO) || (in_type == ELEM_LINETO);

  always_comb begin
    state_next = state;
    count_next = count;
    load_en    = 1'b0;
    box_load   = 1'b0;
    walk_start = 1'b0;
    res_valid  = 1'b0;
    res_inside = 1'b0;
    res_status = 1'b0;
    res_count  = count;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_CLEAR: begin
              count_next = '0;
              res_count  = '0;
              res_valid  = 1'b1;
            end
            KIND_APPEND: begin
              res_valid = 1'b1;
              if (full) begin
                res_status = 1'b1;
              end else begin
                load_en    = 1'b1;
                box_load   = boxed;
                count_next = count + 1'b1;
                res_count  = count + 1'b1;
              end
            end
            KIND_QUERY: begin
              if ((count == '0) || box_out) begin
                res_valid = 1'b1;
              end else begin
                walk_start = 1'b1;
                state_next = ST_WALK;
              end
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      ST_WALK: begin
        if (idx == IDX_WIDTH'(MAX_ELEMENTS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_cnt == DRAIN_WIDTH'(PIPE_DEPTH - 1)) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        res_valid  = 1'b1;
        res_inside = odd;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res_word = OUT_DATA_W'({res_count, res_status, res_inside});

  // ring of cells, cell 0 is the head; a full rotation restores the order
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_ELEMENTS;
    assign cell_ctl[i].load  = load_en && (count[IDX_WIDTH-1:0] == IDX_WIDTH'(i));
    assign cell_ctl[i].shift = state == ST_WALK;
    ppct_cell #(.COORD_WIDTH(W)) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .load_type (in_type),
      .load_x    (in_x),
      .load_y    (in_y),
      .nb_type   (cell_type[NB]),
      .nb_x      (cell_x[NB]),
      .nb_y      (cell_y[NB]),
      .elem_type (cell_type[i]),
      .elem_x    (cell_x[i]),
      .elem_y    (cell_y[i])
    );
  end

  assign head_type  = cell_type[0];
  assign head_x     = cell_x[0];
  assign head_y     = cell_y[0];
  assign live       = (state == ST_WALK) && (COUNT_WIDTH'(idx) < count);
  assign first      = idx == '0;
  assign edge_valid = live && !first && (head_type != ELEM_MOVETO);
  // closepath runs back to the subpath start
  assign end_x      = (head_type == ELEM_CLOSE) ? fx : head_x;
  assign end_y      = (head_type == ELEM_CLOSE) ? fy : head_y;

  ppct_edge #(.COORD_WIDTH(W)) u_edge (
    .clk        (clk),
    .rst        (rst),
    .edge_valid (edge_valid),
    .x1         (p1x),
    .y1         (p1y),
    .x2         (end_x),
    .y2         (end_y),
    .px         (qx),
    .py         (qy),
    .toggle     (toggle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      box_valid  <= 1'b0;
      idx        <= '0;
      drain_cnt  <= '0;
      odd        <= 1'b0;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;

      if (accept && (in_kind == KIND_CLEAR)) begin
        box_valid <= 1'b0;
      end else if (box_load) begin
        box_valid <= 1'b1;
        if (!box_valid) begin
          box_min_x <= in_x;
          box_max_x <= in_x;
          box_min_y <= in_y;
          box_max_y <= in_y;
        end else begin
          if (in_x < box_min_x) box_min_x <= in_x;
          if (in_x > box_max_x) box_max_x <= in_x;
          if (in_y < box_min_y) box_min_y <= in_y;
          if (in_y > box_max_y) box_max_y <= in_y;
        end
      end

      if (walk_start) begin
        qx        <= in_x;
        qy        <= in_y;
        idx       <= '0;
        drain_cnt <= '0;
        odd       <= 1'b0;
      end else begin
        if (state == ST_WALK) idx <= idx + 1'b1;
        if (state == ST_DRAIN) drain_cnt <= drain_cnt + 1'b1;
        if (toggle) odd <= !odd;
      end

      if (live) begin
        if (first || (head_type == ELEM_MOVETO)) begin
          p1x <= head_x;
          p1y <= head_y;
          fx  <= head_x;
          fy  <= head_y;
        end else begin
          p1x <= end_x;
          p1y <= end_y;
        end
      end

      // output register with one pending slot behind it
      if (res_valid) begin
        if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= res_word;
        end else begin
          pend_valid <= 1'b1;
          pend_word  <= res_word;
        end
      end else if (!m_tvalid || m_tready) begin
        m_tvalid   <= pend_valid;
        m_tdata    <= pend_word;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

### design/ppct_checker.sv
// port-level checks of the point-in-path crossing test, bound to the top level
module ppct_checker #(
  parameter  int MAX_ELEMENTS = ppct_pkg::MAX_ELEMENTS_DEF,
  parameter  int COORD_WIDTH  = ppct_pkg::COORD_WIDTH_DEF,
  localparam int COUNT_WIDTH  = $clog2(MAX_ELEMENTS + 1),
  localparam int OUT_DATA_W   = ((2 + COUNT_WIDTH + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [1:0]            s_tuser,   // kind
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata    // inside_res, status, element_count
);

  import ppct_pkg::*;

  logic [COUNT_WIDTH-1:0] out_count;
  assign out_count = m_tdata[COUNT_WIDTH+1:2];

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_full_not_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("dropped append reported inside");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_count <= COUNT_WIDTH'(MAX_ELEMENTS))
    else $error("element count above store size");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_CLEAR) && (!m_tvalid || m_tready)
    |=> m_tvalid && (out_count == '0) && !m_tdata[1] && !m_tdata[0])
    else $error("clear request did not report an empty path");

endmodule

bind point_in_path_crossing_test ppct_checker #(
  .MAX_ELEMENTS (MAX_ELEMENTS),
  .COORD_WIDTH  (COORD_WIDTH)
) u_ppct_checker (.*);
